// ===== sv/indexed_sequence_store_defines.svh =====
// Assertion macros used by the checker file of the indexed sequence store.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define ISS_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ISS_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/iss_pkg.sv =====
// Types, widths and codes shared by the indexed sequence store modules.
package iss_pkg;

   localparam int DEPTH       = 64;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam int MODE_BITS   = 3;
   localparam int POS_BITS    = 7;
   localparam int STATUS_BITS = 2;
   localparam int FOUND_BITS  = 6;
   localparam int LENGTH_BITS = 7;

   localparam int REQ_FIELD_BITS = POS_BITS + WORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = WORD_BITS + FOUND_BITS + LENGTH_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int READ_LSB       = 0;
   localparam int FOUND_LSB      = WORD_BITS;
   localparam int LENGTH_LSB     = WORD_BITS + FOUND_BITS;

   localparam logic [MODE_BITS-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_GET    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_SET    = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_POP    = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_FIND   = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd7;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_INDEX    = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } iss_mem_req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [WORD_BITS-1:0]   read_word;
      logic [FOUND_BITS-1:0]  found_at;
      logic [LENGTH_BITS-1:0] length;
   } iss_result_type;

endpackage

// ===== sv/iss_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
module iss_ram import iss_pkg::*; (
   input  logic                 clock,
   input  iss_mem_req_type      mem_req,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/iss_ctrl.sv =====
// Sequencer that walks the entry memory one address per cycle for insert, get, remove, pop and find.
module iss_ctrl import iss_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [POS_BITS-1:0]    req_position,
   input  logic [WORD_BITS-1:0]   req_word,
   input  logic                   slot_free,
   output logic                   result_valid,
   output iss_result_type         result,
   output iss_mem_req_type        mem_req,
   input  logic [WORD_BITS-1:0]   mem_rdata
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_FIN   = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [WORD_BITS-1:0]   word_ff, word_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [WORD_BITS-1:0]   rd_ff, rd_in;
   logic [FOUND_BITS-1:0]  at_ff, at_in;
   logic [COUNT_BITS-1:0]  cursor_ff, cursor_in;
   logic [COUNT_BITS-1:0]  left_ff, left_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_BITS-1:0]   pend_addr_ff, pend_addr_in;
   logic                   full;

   assign full = (count_ff == COUNT_BITS'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      at_in        = at_ff;
      cursor_in    = cursor_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      mem_req      = '0;
      result_valid = 1'b0;
      result       = '0;
      req_ready    = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               pos_in    = req_position;
               word_in   = req_word;
               rd_in     = '0;
               at_in     = '0;
               status_in = ST_OK;
               pend_in   = 1'b0;
               left_in   = '0;
               cursor_in = COUNT_BITS'(req_position);
               state_in  = S_FIN;
               case (req_mode)
                  MODE_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end
                  end
                  MODE_INSERT: begin
                     if (COUNT_BITS'(req_position) > count_ff) begin
                        status_in = ST_INDEX;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        left_in   = count_ff - COUNT_BITS'(req_position);
                        cursor_in = count_ff - COUNT_BITS'(1);
                        state_in  = S_SWEEP;
                     end
                  end
                  MODE_GET: begin
                     if (COUNT_BITS'(req_position) >= count_ff) begin
                        status_in = ST_INDEX;
                     end else begin
                        left_in  = COUNT_BITS'(1);
                        state_in = S_SWEEP;
                     end
                  end
                  MODE_SET: begin
                     if (COUNT_BITS'(req_position) >= count_ff) begin
                        status_in = ST_INDEX;
                     end
                  end
                  MODE_REMOVE, MODE_POP: begin
                     if (COUNT_BITS'(req_position) >= count_ff) begin
                        status_in = ST_INDEX;
                     end else begin
                        left_in  = count_ff - COUNT_BITS'(req_position);
                        state_in = S_SWEEP;
                     end
                  end
                  MODE_FIND: begin
                     status_in = ST_NOTFOUND;
                     left_in   = count_ff;
                     cursor_in = '0;
                     state_in  = S_SWEEP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SWEEP: begin
            if (left_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cursor_ff[ADDR_BITS-1:0];
               cursor_in = (mode_ff == MODE_INSERT) ? cursor_ff - COUNT_BITS'(1)
                                                     : cursor_ff + COUNT_BITS'(1);
               left_in   = left_ff - COUNT_BITS'(1);
            end
            pend_in      = (left_ff != '0);
            pend_addr_in = cursor_ff[ADDR_BITS-1:0];
            if (left_ff == '0) begin
               state_in = S_FIN;
            end
            if (pend_ff) begin
               case (mode_ff)
                  MODE_INSERT: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pend_addr_ff + ADDR_BITS'(1);
                     mem_req.wr_data = mem_rdata;
                  end
                  MODE_REMOVE, MODE_POP: begin
                     if (pend_addr_ff == pos_ff[ADDR_BITS-1:0]) begin
                        rd_in = mem_rdata;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pend_addr_ff - ADDR_BITS'(1);
                        mem_req.wr_data = mem_rdata;
                     end
                  end
                  MODE_GET: begin
                     rd_in = mem_rdata;
                  end
                  MODE_FIND: begin
                     if (mem_rdata == word_ff) begin
                        status_in = ST_OK;
                        at_in     = FOUND_BITS'(pend_addr_ff);
                        pend_in   = 1'b0;
                        left_in   = '0;
                        state_in  = S_FIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIN: begin
            if (slot_free) begin
               if (status_ff == ST_OK) begin
                  case (mode_ff)
                     MODE_APPEND: begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[ADDR_BITS-1:0];
                        mem_req.wr_data = word_ff;
                        count_in        = count_ff + COUNT_BITS'(1);
                     end
                     MODE_INSERT: begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pos_ff[ADDR_BITS-1:0];
                        mem_req.wr_data = word_ff;
                        count_in        = count_ff + COUNT_BITS'(1);
                     end
                     MODE_SET: begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pos_ff[ADDR_BITS-1:0];
                        mem_req.wr_data = word_ff;
                     end
                     MODE_REMOVE, MODE_POP: begin
                        count_in = count_ff - COUNT_BITS'(1);
                     end
                     MODE_CLEAR: begin
                        count_in = '0;
                     end
                     default: begin
                     end
                  endcase
               end
               result_valid     = 1'b1;
               result.status    = status_ff;
               result.read_word = ((status_ff == ST_OK) && (mode_ff inside {MODE_GET, MODE_POP}))
                                  ? rd_ff : '0;
               result.found_at  = at_ff;
               result.length    = LENGTH_BITS'(count_in);
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      word_ff      <= word_in;
      status_ff    <= status_in;
      rd_ff        <= rd_in;
      at_ff        <= at_in;
      cursor_ff    <= cursor_in;
      pend_addr_ff <= pend_addr_in;
   end

endmodule

// ===== sv/indexed_sequence_store.sv =====
// Append, set, clear and rejected words go straight from acceptance to the finish state.
// Get reads one entry; insert, remove and pop sweep count - position entries, and find
// sweeps at most count entries, stopping at the first match.
// One word is in work at a time; the sweep over the entry memory, one entry per cycle, sets the rate.
// A held result does not block acceptance of the next word.
// Synchronous active-high reset empties the store; entry contents are not cleared.
module indexed_sequence_store import iss_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // position, word
   input  logic [MODE_BITS-1:0]     req_tuser,  // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // read_word, found_at, length
   output logic [STATUS_BITS-1:0]   rsp_tuser   // status
);

   iss_mem_req_type      mem_req;
   logic [WORD_BITS-1:0] mem_rdata;
   logic                 slot_free;
   logic                 result_valid;
   iss_result_type       result;
   logic                 rsp_valid_ff, rsp_valid_in;
   iss_result_type       rsp_ff;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   iss_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   iss_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_mode     (req_tuser),
      .req_position (req_tdata[POS_BITS-1:0]),
      .req_word     (req_tdata[POS_BITS +: WORD_BITS]),
      .slot_free    (slot_free),
      .result_valid (result_valid),
      .result       (result),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata)
   );

   assign rsp_valid_in = result_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}},
                        rsp_ff.length, rsp_ff.found_at, rsp_ff.read_word};

endmodule

// ===== sv/iss_checker.sv =====
// Port-level checks for the indexed sequence store and their binding to it.
`include "indexed_sequence_store_defines.svh"

module iss_checker import iss_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [STATUS_BITS-1:0]   rsp_tuser
);

   `ISS_CHECK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result changed.")
   `ISS_CHECK(a_length_bound, rsp_tvalid |-> rsp_tdata[LENGTH_LSB +: LENGTH_BITS] <= LENGTH_BITS'(DEPTH), "Length above depth.")
   `ISS_CHECK(a_error_zero, rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[READ_LSB +: WORD_BITS] == '0 && rsp_tdata[FOUND_LSB +: FOUND_BITS] == '0, "Error result carries data.")
   `ISS_CHECK(a_busy_after_accept, req_tvalid && req_tready |=> !req_tready, "Ready right after acceptance.")
   `ISS_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "Result valid after reset.")

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (.*);
